### sv/four_level_fsk_pulse_shaper_top_defines.svh
// ---------------------------------------------------------------------------
// four_level_fsk_pulse_shaper_top_defines.svh
// Assertion macros used by the four-level FSK pulse shaper top module
// ---------------------------------------------------------------------------
`ifndef FOUR_LEVEL_FSK_PULSE_SHAPER_TOP_DEFINES_SVH
`define FOUR_LEVEL_FSK_PULSE_SHAPER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define FLFSK_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("flfsk assertion failed");

// same-cycle implication checked on every rising edge outside reset
`define FLFSK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flfsk implication failed");

`else

`define FLFSK_ASSERT(label, clk, rst_n, prop)
`define FLFSK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/flfsk_pkg.sv
// ---------------------------------------------------------------------------
// flfsk_pkg
// Types, symbol levels and Gaussian pulse taps for the 4FSK pulse shaper
// ---------------------------------------------------------------------------
package flfsk_pkg;

    // symbols per input byte
    localparam int SYMS_PER_ITEM = 4;
    localparam int SYM_CNT_W     = $clog2(SYMS_PER_ITEM);

    // widths of the scaling datapath
    localparam int LEVEL_W  = 8;                 // output_level register
    localparam int RAW_W    = 12;                // unscaled symbol level
    localparam int SCL_W    = RAW_W + LEVEL_W;   // level times output_level
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;

    // output_level after reset
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd128;

    // dibit codes
    localparam logic [1:0] DIBIT_P3 = 2'b11;
    localparam logic [1:0] DIBIT_P1 = 2'b10;
    localparam logic [1:0] DIBIT_M1 = 2'b00;
    localparam logic [1:0] DIBIT_M3 = 2'b01;

    // raw symbol levels
    localparam logic signed [RAW_W-1:0] LEVEL_P3 = 12'sd1362;
    localparam logic signed [RAW_W-1:0] LEVEL_P1 = 12'sd454;
    localparam logic signed [RAW_W-1:0] LEVEL_M1 = -12'sd454;
    localparam logic signed [RAW_W-1:0] LEVEL_M3 = -12'sd1362;

    // one half of the Gaussian pulse, center tap first
    localparam int PULSE_HALF_LEN = 7;
    localparam logic [15:0] PULSE_HALF [PULSE_HALF_LEN] = '{
        16'd32767, 16'd30728, 16'd22736, 16'd10668, 16'd2659, 16'd319, 16'd17
    };

    // scaler command and result
    typedef struct packed {
        logic       start;
        logic [1:0] dibit;
        logic       silence;
    } t_scl_cmd;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] symbol;
    } t_scl_result;

    // filter command and result
    typedef struct packed {
        logic load;     // push a new symbol into the window
        logic start;    // begin one output phase
    } t_fir_cmd;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] sample;
    } t_fir_result;

    // dibit to raw level
    function automatic logic signed [RAW_W-1:0] level_of(input logic [1:0] dibit);
        logic signed [RAW_W-1:0] lvl;
        unique case (dibit)
            DIBIT_P3: lvl = LEVEL_P3;
            DIBIT_P1: lvl = LEVEL_P1;
            DIBIT_M1: lvl = LEVEL_M1;
            DIBIT_M3: lvl = LEVEL_M3;
            default:  lvl = LEVEL_M3;
        endcase
        return lvl;
    endfunction

    // filter tap k of a pulse centered on tap center, zero away from the pulse
    function automatic logic [15:0] tap_value(input int k, input int center);
        int d;
        d = k - center;
        if (d < 0) begin
            d = -d;
        end
        if (d >= PULSE_HALF_LEN) begin
            return 16'd0;
        end
        return PULSE_HALF[d[2:0]];
    endfunction

endpackage

### sv/flfsk_scaler.sv
// ---------------------------------------------------------------------------
// flfsk_scaler
// Bit-serial gain stage: raw level times output_level, one gain bit a cycle
// ---------------------------------------------------------------------------
module flfsk_scaler
    import flfsk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_scl_cmd             i_cmd,
    input  logic [LEVEL_W-1:0]   i_level,
    output t_scl_result          o_res
);

    localparam int CNT_W = $clog2(LEVEL_W);

    logic signed [SCL_W-1:0] r_mcand;
    logic [LEVEL_W-1:0]      r_mplier;
    logic signed [SCL_W-1:0] r_acc;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    // shift-and-add over the gain bits, lsb first; silence uses a zero gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_cmd.start && (r_cnt == CNT_W'(LEVEL_W - 1));
            if (i_cmd.start) begin
                r_mcand  <= SCL_W'(level_of(i_cmd.dibit));
                r_mplier <= i_cmd.silence ? '0 : i_level;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // gain is output_level * 128 in q15, so drop 8 bits with floor
    assign o_res.done   = r_done;
    assign o_res.symbol = SAMPLE_W'(r_acc >>> 8);

endmodule

### sv/flfsk_fir.sv
// ---------------------------------------------------------------------------
// flfsk_fir
// Polyphase Gaussian FIR: symbol window rotates past one shared multiplier
// ---------------------------------------------------------------------------
module flfsk_fir
    import flfsk_pkg::*;
#(
    parameter int SPS  = 5,
    parameter int TAPS = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_fir_cmd                    i_cmd,
    input  logic [$clog2(SPS)-1:0]      i_phase,
    input  logic signed [SAMPLE_W-1:0]  i_symbol,
    output t_fir_result                 o_res
);

    localparam int NUM_TAPS = SPS * TAPS;
    localparam int CENTER   = (NUM_TAPS - 1) / 2;
    localparam int IDX_W    = $clog2(NUM_TAPS + SPS);
    localparam int CNT_W    = $clog2(TAPS);
    localparam int ACC_W    = PROD_W + $clog2(TAPS) + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32768);

    logic signed [SAMPLE_W-1:0] r_win [TAPS];
    logic [IDX_W-1:0]           r_tap_idx;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_vld;
    logic                       r_prod_last;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_fin;

    logic [15:0]                tap;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]    acc_shr;
    logic signed [SAMPLE_W-1:0] sat_sample;

    assign tap    = tap_value(int'(r_tap_idx), CENTER);
    assign n_prod = r_win[0] * signed'(tap);

    // symbol window: shift in a new symbol, or rotate once per tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[TAPS - 1] <= i_symbol;
        end else if (r_busy) begin
            for (int i = 0; i < TAPS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[TAPS - 1] <= r_win[0];
        end
    end

    // tap sequencing, registered product, accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_prod_last <= 1'b0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_prod_vld  <= r_busy && !i_cmd.start;
            r_prod_last <= r_busy && !i_cmd.start && (r_cnt == CNT_W'(TAPS - 1));
            r_fin       <= r_prod_vld && r_prod_last;
            if (i_cmd.start) begin
                r_tap_idx <= IDX_W'(SPS - 1) - IDX_W'(i_phase);
                r_cnt     <= '0;
                r_busy    <= 1'b1;
                r_acc     <= '0;
            end else begin
                if (r_busy) begin
                    r_prod      <= n_prod;
                    r_tap_idx   <= r_tap_idx + IDX_W'(SPS);
                    r_cnt       <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(TAPS - 1)) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_prod_vld) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
            end
        end
    end

    // floor shift by 15 and saturate to 16 bits
    assign acc_shr = r_acc >>> 15;

    always_comb begin
        if (acc_shr > SAT_MAX) begin
            sat_sample = 16'sh7fff;
        end else if (acc_shr < SAT_MIN) begin
            sat_sample = 16'sh8000;
        end else begin
            sat_sample = acc_shr[SAMPLE_W-1:0];
        end
    end

    assign o_res.sample = sat_sample;
    assign o_res.done   = r_fin;

endmodule

### sv/four_level_fsk_pulse_shaper_top.sv
// ---------------------------------------------------------------------------
// four_level_fsk_pulse_shaper_top
// Four-level FSK symbol mapper with Gaussian polyphase interpolation
// ---------------------------------------------------------------------------
// s_axis takes one transaction per byte (tdata) or silence item (tuser[0] = 1)
// and m_axis returns 4 * SAMPLES_PER_SYMBOL q15 samples for it, tlast on the
// final one. The cfg channel, always ready, writes the amplitude register;
// write it only while the block is idle.
// One item is worked on at a time. Each symbol first passes the
// bit-serial gain stage, then each of its SAMPLES_PER_SYMBOL phases passes
// the shared multiply-accumulate unit over TAPS_PER_PHASE taps; the next item
// is taken once the final sample of the last one is in the output register.
// The first sample reaches the output register after the gain stage and the
// first filter phase. Reset is synchronous, active low; it clears the symbol
// window and sets the amplitude register to 128.
// While m_axis_tready is low a sample waits in the output register and work
// pauses; the next item is taken while the final sample still waits.
// ---------------------------------------------------------------------------
`include "four_level_fsk_pulse_shaper_top_defines.svh"

module four_level_fsk_pulse_shaper_top
    import flfsk_pkg::*;
#(
    parameter int SAMPLES_PER_SYMBOL = 5,
    parameter int TAPS_PER_PHASE     = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // [7:0] output_level
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] silence
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample
    output logic        m_axis_tlast    // last
);

    localparam int PH_W = $clog2(SAMPLES_PER_SYMBOL);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_MAC,
        S_EMIT
    } t_state;

    t_state                     r_state;
    logic [LEVEL_W-1:0]         r_level;
    logic [7:0]                 r_byte;
    logic                       r_silence;
    logic [SYM_CNT_W-1:0]       r_sym_cnt;
    logic [PH_W-1:0]            r_phase;
    logic                       r_scl_start;
    t_fir_cmd                   r_fir_cmd;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic                       r_m_valid;
    logic [SAMPLE_W-1:0]        r_m_data;
    logic                       r_m_last;

    t_scl_cmd                   scl_cmd;
    t_scl_result                scl_res;
    t_fir_result                fir_res;
    logic                       last_phase;
    logic                       last_sym;
    logic                       accept;
    logic                       scl_go;
    logic                       emit_go;
    logic                       item_done;

    assign last_phase = (r_phase == PH_W'(SAMPLES_PER_SYMBOL - 1));
    assign last_sym   = (r_sym_cnt == SYM_CNT_W'(SYMS_PER_ITEM - 1));

    // handshake and step conditions
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign scl_go    = (r_state == S_SCALE) && scl_res.done;
    assign emit_go   = (r_state == S_EMIT) && (!r_m_valid || m_axis_tready);
    assign item_done = emit_go && last_phase && last_sym;

    // gain stage
    assign scl_cmd = '{start: r_scl_start, dibit: r_byte[7:6], silence: r_silence};

    flfsk_scaler u_scaler (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (scl_cmd),
        .i_level (r_level),
        .o_res   (scl_res)
    );

    // interpolating filter
    flfsk_fir #(
        .SPS  (SAMPLES_PER_SYMBOL),
        .TAPS (TAPS_PER_PHASE)
    ) u_fir (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (r_fir_cmd),
        .i_phase  (r_phase),
        .i_symbol (scl_res.symbol),
        .o_res    (fir_res)
    );

    // sequencer, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= LEVEL_RESET;
            r_sym_cnt   <= '0;
            r_phase     <= '0;
            r_scl_start <= 1'b0;
            r_fir_cmd   <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_scl_start <= accept || (emit_go && last_phase && !last_sym);
            r_fir_cmd   <= '{load: scl_go, start: scl_go || (emit_go && !last_phase)};
            r_m_valid   <= emit_go || (r_m_valid && !m_axis_tready);
            if (i_cfg_valid) begin
                r_level <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_byte      <= s_axis_tdata;
                        r_silence   <= s_axis_tuser[0];
                        r_sym_cnt   <= '0;
                        r_phase     <= '0;
                        r_state     <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    if (scl_res.done) begin
                        r_phase   <= '0;
                        r_state   <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (fir_res.done) begin
                        r_smp   <= fir_res.sample;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_m_data  <= r_smp;
                        r_m_last  <= last_phase && last_sym;
                        if (!last_phase) begin
                            r_phase   <= r_phase + 1'b1;
                            r_state   <= S_MAC;
                        end else if (!last_sym) begin
                            r_sym_cnt   <= r_sym_cnt + 1'b1;
                            r_byte      <= {r_byte[5:0], 2'b00};
                            r_state     <= S_SCALE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

    // checks
    `FLFSK_ASSERT(a_accept_scale, i_clk, i_rst_n, accept |=> (r_scl_start && r_state == S_SCALE))
    `FLFSK_ASSERT_IMPLIES(a_scl_done_in_scale, i_clk, i_rst_n, scl_res.done, r_state == S_SCALE)
    `FLFSK_ASSERT_IMPLIES(a_fir_done_in_mac, i_clk, i_rst_n, fir_res.done, r_state == S_MAC)
    `FLFSK_ASSERT(a_last_item, i_clk, i_rst_n, item_done |=> (m_axis_tlast && r_state == S_IDLE))

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks the four-level FSK pulse shaper sample by sample. Bytes and silence
// items go in on s_axis, and each one is run through a local model of the
// dibit mapper, the gain stage and the Gaussian polyphase filter. The output
// samples and tlast are compared in order, under random stalls on both
// streams and several amplitude settings.
// ---------------------------------------------------------------------------
module testbench;
    import flfsk_pkg::*;

    localparam int SPS            = 5;
    localparam int TPP            = 9;
    localparam int ITEM_SAMPLES   = SYMS_PER_ITEM * SPS;
    localparam int CENTER_TAP     = (SPS * TPP - 1) / 2;
    localparam int TIMEOUT_CYCLES = 1_500_000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int HOLD_CYCLES    = 1500;
    localparam int RANDOM_PHASES  = 4;
    localparam int PHASE_ITEMS    = 95;

    // gaussian pulse, center tap first
    localparam int GAUSS_HALF [7] = '{32767, 30728, 22736, 10668, 2659, 319, 17};

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_shaped_sample;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic [0:0]  s_axis_tuser = '0;     // [0] silence
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] sample
    logic        m_axis_tlast;

    // model state and expected samples
    logic [7:0]         level_setting = LEVEL_RESET;
    logic signed [15:0] symbol_window [TPP-1] = '{default: '0};
    t_shaped_sample     pending_samples [$];
    int                 mismatch_count = 0;
    bit                 idle_on = 1'b1;
    int                 hold_request = 0;

    always #5 i_clk = ~i_clk;

    four_level_fsk_pulse_shaper_top #(
        .SAMPLES_PER_SYMBOL(SPS),
        .TAPS_PER_PHASE    (TPP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic int gauss_tap(input int k);
        int d;
        d = (k > CENTER_TAP) ? k - CENTER_TAP : CENTER_TAP - k;
        return (d < 7) ? GAUSS_HALF[d] : 0;
    endfunction

    // dibit to level, times output_level * 128, floor shift and saturate
    function automatic logic signed [15:0] scaled_symbol(input logic [1:0] dibit);
        logic signed [RAW_W-1:0] raw;
        longint                  gain;
        case (dibit)
            DIBIT_P3: raw = LEVEL_P3;
            DIBIT_P1: raw = LEVEL_P1;
            DIBIT_M1: raw = LEVEL_M1;
            DIBIT_M3: raw = LEVEL_M3;
            default:  raw = '0;
        endcase
        gain = longint'(level_setting) * 128;
        return sat16((longint'(raw) * gain) >>> 15);
    endfunction

    // four symbols through the polyphase filter, queue the 20 samples
    task automatic shape_item(input logic [7:0] data_byte, input logic silence);
        logic signed [15:0] sym;
        logic signed [15:0] win [TPP];
        longint             acc;
        t_shaped_sample     smp;
        int                 n;
        n = 0;
        for (int s = 0; s < SYMS_PER_ITEM; s++) begin
            sym = silence ? 16'sd0 : scaled_symbol(data_byte[7-2*s -: 2]);
            for (int t = 0; t < TPP - 1; t++) begin
                win[t] = symbol_window[t];
            end
            win[TPP-1] = sym;
            for (int p = 0; p < SPS; p++) begin
                acc = 0;
                for (int t = 0; t < TPP; t++) begin
                    acc += longint'(win[t]) * longint'(gauss_tap((SPS - 1 - p) + t * SPS));
                end
                smp.sample = sat16(acc >>> 15);
                smp.last   = (n == ITEM_SAMPLES - 1);
                pending_samples.push_back(smp);
                n++;
            end
            for (int t = 0; t < TPP - 1; t++) begin
                symbol_window[t] = win[t + 1];
            end
        end
    endtask

    // one input transaction, valid stays high for a back-to-back follower
    task automatic send_byte(input logic [7:0] data_byte, input logic silence);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid   <= 1'b1;
        s_axis_tdata    <= data_byte;
        s_axis_tuser[0] <= silence;
        do @(posedge i_clk); while (!s_axis_tready);
        shape_item(data_byte, silence);
    endtask

    // drop valid and wait for every expected sample
    task automatic drain_samples();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_level(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        level_setting = value;
    endtask

    // every dibit and silence at the reset amplitude
    task automatic test_symbol_map();
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h1b, 1'b0);
        send_byte(8'he4, 1'b0);
        // silence ignores the data byte
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b1);
        drain_samples();
    endtask

    // amplitude register at zero, full scale and one
    task automatic test_level_extremes();
        write_level(8'd0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h5a, 1'b1);
        drain_samples();
        write_level(8'd255);
        send_byte(8'hff, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h3c, 1'b1);
        drain_samples();
        write_level(8'd1);
        send_byte(8'he4, 1'b0);
        drain_samples();
    endtask

    // output held off for a long stretch while input keeps coming
    task automatic test_back_pressure();
        idle_on = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 8; i++) begin
            send_byte(8'($urandom), 1'b0);
        end
        drain_samples();
        idle_on = 1'b1;
    endtask

    // random bytes with some silence, a new amplitude per phase
    task automatic test_random_traffic();
        logic [7:0] lvl;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1:       lvl = 8'd255;
                3:       lvl = 8'd0;
                default: lvl = 8'($urandom_range(0, 255));
            endcase
            write_level(lvl);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
            end
            drain_samples();
        end
        idle_on = 1'b1;
    endtask

    // output side: check each transaction, then pick ready for the next cycle
    initial begin : sample_monitor
        t_shaped_sample want;
        int             stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (pending_samples.size() == 0) begin
                    $error("sample: expected none, actual %0d", $signed(m_axis_tdata));
                    mismatch_count++;
                end else begin
                    want = pending_samples.pop_front();
                    if (m_axis_tdata !== want.sample) begin
                        $error("sample: expected %0d, actual %0d",
                               want.sample, $signed(m_axis_tdata));
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_symbol_map();
        test_level_extremes();
        test_back_pressure();
        test_random_traffic();
        drain_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_samples.size() != 0) begin
            $error("sample: expected %0d more, actual none", pending_samples.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### four_level_fsk_pulse_shaper_top.f
+incdir+sv
sv/flfsk_pkg.sv
sv/flfsk_scaler.sv
sv/flfsk_fir.sv
sv/four_level_fsk_pulse_shaper_top.sv
test/testbench.sv
